### src/rkd_pkg.sv
`default_nettype none
package rkd_pkg;

    localparam int DATA_W      = 32;
    localparam int PRIME_W     = 16;
    localparam int STAT_W      = 2;
    localparam int ROOT_W      = PRIME_W / 2 + 1;
    localparam int CNT_W       = $clog2(DATA_W) + 1;
    localparam int ADDR_W      = 2;
    localparam int PRIME_BITS_DEF = 16;

    localparam logic [ADDR_W-1:0] REG_PRIME_P    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_PRIME_Q    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_PUBLIC_EXP = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_BAD_P,
        ST_BAD_Q,
        ST_BAD_EXP
    } status_t;

    localparam logic [PRIME_W-1:0] RESET_P = 16'd3;
    localparam logic [PRIME_W-1:0] RESET_Q = 16'd11;
    localparam logic [DATA_W-1:0]  RESET_E = 32'd3;

endpackage
`default_nettype wire

### src/rkd_divider.sv
`default_nettype none
module rkd_divider
    import rkd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient,
    output logic [DATA_W-1:0]      remainder
);

    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        trial     = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DATA_W-1:0];

endmodule
`default_nettype wire

### src/rkd_mulmod.sv
`default_nettype none
module rkd_mulmod
    import rkd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] op_a,
    input  wire logic [DATA_W-1:0] op_b,
    input  wire logic [DATA_W-1:0] modulus,
    output logic                   done,
    output logic [DATA_W-1:0]      product
);

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] m_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   dbl;
    logic [DATA_W:0]   dbl_red;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   sum_red;

    // Interleaved multiply: walk op_a from the top bit, doubling the
    // accumulator and adding op_b, keeping it below the modulus.
    // op_b must be below the modulus; op_a may be any value.
    always_comb
    begin
        dbl       = {acc_reg, 1'b0};
        dbl_red   = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum       = dbl_red + (a_reg[DATA_W-1] ? {1'b0, b_reg} : '0);
        sum_red   = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = op_a;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[DATA_W-1:0];
            a_next   = {a_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        if (start)
        begin
            b_reg <= op_b;
            m_reg <= modulus;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

### src/rsa_key_derive_and_modexp_core.sv
// Small RSA engine with key derivation.
// Configuration: cfg_we/cfg_addr/cfg_wdata write prime_p (0), prime_q (1)
// and public_exp (2); any valid write marks the key stale.
// Requests: a beat on s_axis carries the value in tdata and the command in
// tuser (0 encrypt with e, 1 decrypt with d). One result beat follows on
// m_axis with the result, d and n in tdata and the status in tuser.
// The first request after reset or a register write first derives the
// key: trial division of p and q by each divisor up to the square root,
// then an extended Euclid pass with one divide and one multiply per step.
// Every request with a good key reduces the message modulo n and runs a
// square-and-multiply over the exponent bits, one serial multiply per
// square plus one per set bit; a request with a bad key skips this.
// Requests are processed one at a time; s_axis_tready is high only while
// the engine is idle. The result sits in an output register, so a new
// request is taken while a result waits; when the receiver stalls, the
// finished next result waits in the engine until the register frees up.
// Reset restores p = 3, q = 11, e = 3, clears the key and the output valid.
`default_nettype none
module rsa_key_derive_and_modexp_core
    import rkd_pkg::*;
#(
    parameter int PRIME_BITS = PRIME_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [ADDR_W-1:0]   cfg_addr,
    input  wire logic [DATA_W-1:0]   cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // message_value
    input  wire logic [DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  wire logic [0:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // result_value, derived_private_exp, modulus_out
    output logic [3*DATA_W-1:0]      m_axis_tdata,
    // status
    output logic [STAT_W-1:0]        m_axis_tuser
);

    localparam int PB = (PRIME_BITS > PRIME_W) ? PRIME_W : PRIME_BITS;
    localparam logic [PRIME_W-1:0] PMASK = PRIME_W'((33'd1 << PB) - 33'd1);

    typedef enum logic [4:0] {
        S_IDLE, S_KEY, S_PR_INIT, S_PR_TEST, S_PR_WAIT, S_EXP_CHK, S_EU_R1,
        S_EU_LOOP, S_EU_DIV, S_EU_MUL, S_RUN, S_ME_RED, S_ME_BIT, S_ME_ACC,
        S_ME_SQ, S_DONE
    } state_t;

    state_t             state_reg;
    logic [PRIME_W-1:0] p_reg, q_reg;
    logic [DATA_W-1:0]  e_reg;
    logic [DATA_W-1:0]  n_reg, tot_reg, d_reg;
    status_t            status_reg;
    logic               key_ready_reg;
    logic               cmd_reg;
    logic [DATA_W-1:0]  msg_reg;
    logic               sel_reg;
    logic [ROOT_W-1:0]  j_reg;
    logic [DATA_W-1:0]  r0_reg, r1_reg, t0_reg, t1_reg, r2_reg;
    logic [DATA_W-1:0]  base_reg, acc_reg, ex_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_res_reg, out_d_reg, out_n_reg;
    status_t            out_status_reg;

    logic               div_start_reg, mul_start_reg;
    logic [DATA_W-1:0]  div_a_reg, div_b_reg, mul_a_reg, mul_b_reg, mul_m_reg;
    logic               div_done, mul_done;
    logic [DATA_W-1:0]  div_quo, div_rem, mul_prod;

    logic [PRIME_W-1:0]  cand;
    logic [2*ROOT_W-1:0] j_sq;
    logic [DATA_W-1:0]   t2;

    rkd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rkd_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .modulus (mul_m_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign cand = sel_reg ? q_reg : p_reg;
    assign j_sq = j_reg * j_reg;
    // Euclid coefficients are kept reduced modulo the totient.
    assign t2 = (t0_reg >= mul_prod) ? t0_reg - mul_prod
                                     : t0_reg + tot_reg - mul_prod;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_n_reg, out_d_reg, out_res_reg};
    assign m_axis_tuser  = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            p_reg          <= RESET_P;
            q_reg          <= RESET_Q;
            e_reg          <= RESET_E;
            n_reg          <= '0;
            tot_reg        <= '0;
            d_reg          <= '0;
            status_reg     <= ST_OK;
            key_ready_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PRIME_P:
                    begin
                        p_reg         <= cfg_wdata[PRIME_W-1:0] & PMASK;
                        key_ready_reg <= 1'b0;
                    end
                    REG_PRIME_Q:
                    begin
                        q_reg         <= cfg_wdata[PRIME_W-1:0] & PMASK;
                        key_ready_reg <= 1'b0;
                    end
                    REG_PUBLIC_EXP:
                    begin
                        e_reg         <= cfg_wdata;
                        key_ready_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg   <= s_axis_tuser[0];
                        msg_reg   <= s_axis_tdata;
                        state_reg <= key_ready_reg ? S_RUN : S_KEY;
                    end
                end
                S_KEY:
                begin
                    n_reg   <= DATA_W'(p_reg) * DATA_W'(q_reg);
                    tot_reg <= (p_reg != '0 && q_reg != '0)
                               ? DATA_W'(p_reg - 1'b1) * DATA_W'(q_reg - 1'b1) : '0;
                    d_reg   <= '0;
                    sel_reg <= 1'b0;
                    state_reg <= S_PR_INIT;
                end
                S_PR_INIT:
                begin
                    j_reg <= ROOT_W'(2);
                    if (cand < PRIME_W'(2))
                    begin
                        status_reg    <= sel_reg ? ST_BAD_Q : ST_BAD_P;
                        key_ready_reg <= 1'b1;
                        state_reg     <= S_RUN;
                    end
                    else
                    begin
                        state_reg <= S_PR_TEST;
                    end
                end
                S_PR_TEST:
                begin
                    if (j_sq > (2*ROOT_W)'(cand))
                    begin
                        div_start_reg <= 1'b0;
                        sel_reg       <= 1'b1;
                        state_reg     <= sel_reg ? S_EXP_CHK : S_PR_INIT;
                    end
                    else
                    begin
                        div_a_reg     <= DATA_W'(cand);
                        div_b_reg     <= DATA_W'(j_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_PR_WAIT;
                    end
                end
                S_PR_WAIT:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            status_reg    <= sel_reg ? ST_BAD_Q : ST_BAD_P;
                            key_ready_reg <= 1'b1;
                            state_reg     <= S_RUN;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_PR_TEST;
                        end
                    end
                end
                S_EXP_CHK:
                begin
                    if (e_reg < DATA_W'(2) || tot_reg < DATA_W'(2))
                    begin
                        div_start_reg <= 1'b0;
                        status_reg    <= ST_BAD_EXP;
                        key_ready_reg <= 1'b1;
                        state_reg     <= S_RUN;
                    end
                    else
                    begin
                        div_a_reg     <= e_reg;
                        div_b_reg     <= tot_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_EU_R1;
                    end
                end
                S_EU_R1:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        r0_reg    <= tot_reg;
                        r1_reg    <= div_rem;
                        t0_reg    <= '0;
                        t1_reg    <= DATA_W'(1);
                        state_reg <= S_EU_LOOP;
                    end
                end
                S_EU_LOOP:
                begin
                    div_start_reg <= (r1_reg != '0);
                    if (r1_reg == '0)
                    begin
                        key_ready_reg <= 1'b1;
                        state_reg     <= S_RUN;
                        if (r0_reg != DATA_W'(1))
                        begin
                            status_reg <= ST_BAD_EXP;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            d_reg <= (t0_reg < DATA_W'(2)) ? t0_reg + tot_reg : t0_reg;
                        end
                    end
                    else
                    begin
                        div_a_reg     <= r0_reg;
                        div_b_reg     <= r1_reg;
                        state_reg     <= S_EU_DIV;
                    end
                end
                S_EU_DIV:
                begin
                    div_start_reg <= 1'b0;
                    mul_start_reg <= div_done;
                    if (div_done)
                    begin
                        r2_reg        <= div_rem;
                        mul_a_reg     <= div_quo;
                        mul_b_reg     <= t1_reg;
                        mul_m_reg     <= tot_reg;
                        state_reg     <= S_EU_MUL;
                    end
                end
                S_EU_MUL:
                begin
                    mul_start_reg <= 1'b0;
                    if (mul_done)
                    begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= r2_reg;
                        t0_reg    <= t1_reg;
                        t1_reg    <= t2;
                        state_reg <= S_EU_LOOP;
                    end
                end
                S_RUN:
                begin
                    acc_reg       <= (status_reg != ST_OK) ? '0 : DATA_W'(1);
                    ex_reg        <= (cmd_reg == CMD_DECRYPT) ? d_reg : e_reg;
                    div_start_reg <= (status_reg == ST_OK);
                    if (status_reg != ST_OK)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        div_a_reg     <= msg_reg;
                        div_b_reg     <= n_reg;
                        state_reg     <= S_ME_RED;
                    end
                end
                S_ME_RED:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        base_reg  <= div_rem;
                        state_reg <= S_ME_BIT;
                    end
                end
                S_ME_BIT:
                begin
                    mul_m_reg     <= n_reg;
                    mul_start_reg <= (ex_reg != '0);
                    if (ex_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (ex_reg[0])
                    begin
                        mul_a_reg <= acc_reg;
                        mul_b_reg <= base_reg;
                        state_reg <= S_ME_ACC;
                    end
                    else
                    begin
                        mul_a_reg <= base_reg;
                        mul_b_reg <= base_reg;
                        state_reg <= S_ME_SQ;
                    end
                end
                S_ME_ACC:
                begin
                    mul_start_reg <= mul_done;
                    if (mul_done)
                    begin
                        acc_reg       <= mul_prod;
                        mul_a_reg     <= base_reg;
                        mul_b_reg     <= base_reg;
                        state_reg     <= S_ME_SQ;
                    end
                end
                S_ME_SQ:
                begin
                    mul_start_reg <= 1'b0;
                    if (mul_done)
                    begin
                        base_reg  <= mul_prod;
                        ex_reg    <= {1'b0, ex_reg[DATA_W-1:1]};
                        state_reg <= S_ME_BIT;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_res_reg    <= (status_reg == ST_OK) ? acc_reg : '0;
                        out_d_reg      <= (status_reg == ST_OK) ? d_reg : '0;
                        out_n_reg      <= n_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### src/rkd_checker.sv
`default_nettype none
module rkd_checker
    import rkd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [3*DATA_W-1:0]  m_axis_tdata,
    input wire logic [STAT_W-1:0]    m_axis_tuser
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Failed key derivation reports zero result and zero private exponent.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |->
            m_axis_tdata[2*DATA_W-1:0] == '0)
        else $error("error beat carries nonzero result");

    // A good result is reduced below the modulus.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OK |->
            m_axis_tdata[DATA_W-1:0] < m_axis_tdata[3*DATA_W-1:2*DATA_W])
        else $error("result not below modulus");

    // The engine takes one request at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind rsa_key_derive_and_modexp_core rkd_checker u_rkd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
